// ----- hdl/tkd_pkg.sv -----
`timescale 1ns / 1ps
// package: key codes, byte constants, handshake structs and decode functions
package tkd_pkg;

	// longest escape sequence kept before it is dropped
	localparam int ESC_MAX = 16;
	localparam int PLEN_W  = $clog2(ESC_MAX);

	localparam logic [7:0] B_ESC    = 8'h1B;
	localparam logic [7:0] B_CSI    = 8'h5B;
	localparam logic [7:0] B_SS3    = 8'h4F;
	localparam logic [7:0] B_SPACE  = 8'h20;
	localparam logic [7:0] B_FIN_LO = 8'h40;
	localparam logic [7:0] B_FIN_HI = 8'h7E;
	localparam logic [7:0] B_DEL    = 8'h7F;

	typedef enum logic [4:0] {
		KEY_NONE      = 5'd0,
		KEY_CHAR      = 5'd1,
		KEY_ENTER     = 5'd2,
		KEY_TAB       = 5'd3,
		KEY_BKSP      = 5'd4,
		KEY_CTRL_C    = 5'd5,
		KEY_CTRL_D    = 5'd6,
		KEY_CTRL_L    = 5'd7,
		KEY_CTRL_U    = 5'd8,
		KEY_CTRL_W    = 5'd9,
		KEY_ESCAPE    = 5'd10,
		KEY_UP        = 5'd11,
		KEY_DOWN      = 5'd12,
		KEY_RIGHT     = 5'd13,
		KEY_LEFT      = 5'd14,
		KEY_HOME      = 5'd15,
		KEY_END       = 5'd16,
		KEY_DELETE    = 5'd17,
		KEY_PGUP      = 5'd18,
		KEY_PGDN      = 5'd19,
		KEY_PASTE_BEG = 5'd20,
		KEY_PASTE_END = 5'd21
	} key_t;

	typedef struct packed {
		logic load;
		logic step;
		logic push;
		logic push_last;
	} tkd_cmd_t;

	typedef struct packed {
		logic work;
		logic emit;
		logic held_valid;
		logic out_free;
	} tkd_stat_t;

	// control bytes with a key of their own
	function automatic key_t ctl_key(input logic [7:0] c);
		key_t k;
		k = KEY_NONE;
		case (c)
			8'h0D, 8'h0A: k = KEY_ENTER;
			8'h09:        k = KEY_TAB;
			8'h7F, 8'h08: k = KEY_BKSP;
			8'h03:        k = KEY_CTRL_C;
			8'h04:        k = KEY_CTRL_D;
			8'h0C:        k = KEY_CTRL_L;
			8'h15:        k = KEY_CTRL_U;
			8'h17:        k = KEY_CTRL_W;
			default:      k = KEY_NONE;
		endcase
		return k;
	endfunction

	// total length of a utf-8 char from its lead, zero when not a lead
	function automatic logic [2:0] utf8_len(input logic [7:0] c);
		logic [2:0] n;
		n = 3'd0;
		if (c[7] == 1'b0)
			n = 3'd1;
		else if (c[7:5] == 3'b110)
			n = 3'd2;
		else if (c[7:4] == 4'b1110)
			n = 3'd3;
		else if (c[7:3] == 5'b11110)
			n = 3'd4;
		return n;
	endfunction

	// key for a csi/ss3 final byte and its exact parameter string
	function automatic key_t seq_key(input logic [PLEN_W-1:0] plen, input logic [7:0] p0,
			input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] fin);
		key_t k;
		k = KEY_NONE;
		if (plen == PLEN_W'(0)) begin
			case (fin)
				8'h41:   k = KEY_UP;
				8'h42:   k = KEY_DOWN;
				8'h43:   k = KEY_RIGHT;
				8'h44:   k = KEY_LEFT;
				8'h48:   k = KEY_HOME;
				8'h46:   k = KEY_END;
				default: k = KEY_NONE;
			endcase
		end else if (fin == B_FIN_HI) begin
			if (plen == PLEN_W'(1)) begin
				case (p0)
					8'h31, 8'h37: k = KEY_HOME;
					8'h33:        k = KEY_DELETE;
					8'h34, 8'h38: k = KEY_END;
					8'h35:        k = KEY_PGUP;
					8'h36:        k = KEY_PGDN;
					default:      k = KEY_NONE;
				endcase
			end else if (plen == PLEN_W'(3) && p0 == 8'h32 && p1 == 8'h30) begin
				if (p2 == 8'h30)
					k = KEY_PASTE_BEG;
				else if (p2 == 8'h31)
					k = KEY_PASTE_END;
			end
		end
		return k;
	endfunction

endpackage

// ----- hdl/tkd_ctrl.sv -----
`timescale 1ns / 1ps
// controller: input acceptance and sequencing of decode steps and result pushes
module tkd_ctrl import tkd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  tkd_stat_t stat,
	output tkd_cmd_t  cmd
);

	typedef enum logic {
		C_IDLE,
		C_RUN
	} cstate_t;

	cstate_t state_q;
	cstate_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_stall = 1'b1;
		case (state_q)
			C_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = C_RUN;
				end
			end
			C_RUN: begin
				if (stat.work) begin
					// a new result displaces the held one only when the output can take it
					if (!(stat.emit && stat.held_valid)) begin
						cmd.step = 1'b1;
					end else if (stat.out_free) begin
						cmd.step = 1'b1;
						cmd.push = 1'b1;
					end
				end else if (!stat.held_valid) begin
					state_nx = C_IDLE;
				end else if (stat.out_free) begin
					cmd.push_last = 1'b1;
					state_nx      = C_IDLE;
				end
			end
			default: state_nx = C_IDLE;
		endcase
	end

endmodule

// ----- hdl/tkd_dp.sv -----
`timescale 1ns / 1ps
// datapath: byte queue, parser state, held result and output register
module tkd_dp import tkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  tkd_cmd_t    cmd,
	output tkd_stat_t   stat,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [4:0]  key_code,
	output logic [31:0] char_bytes,
	output logic [2:0]  char_len,
	output logic [4:0]  consumed,
	output logic        last
);

	typedef enum logic [1:0] {
		PM_IDLE,
		PM_ESC,
		PM_SEQ,
		PM_UTF
	} pmode_t;

	// parser state
	pmode_t            mode_q;
	pmode_t            m_nx;
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] plen_nx;
	logic [7:0]        prm_q [3];
	logic [7:0]        prm_nx [3];
	logic [7:0]        ub_q [3];
	logic [7:0]        ub_nx [3];
	logic [1:0]        ucnt_q;
	logic [1:0]        ucnt_nx;
	logic [2:0]        uneed_q;
	logic [2:0]        uneed_nx;

	// bytes still to be decoded in this word
	logic [7:0]        rq_q [3];
	logic [7:0]        rq_nx [3];
	logic [1:0]        rcnt_q;
	logic [1:0]        rcnt_nx;
	logic              flush_q;
	logic              flush_nx;

	// result of one step
	logic              e_emit;
	key_t              e_code;
	logic [31:0]       e_bytes;
	logic [2:0]        e_len;
	logic [4:0]        e_cons;

	logic              hv_q;
	key_t              h_code_q;
	logic [31:0]       h_bytes_q;
	logic [2:0]        h_len_q;
	logic [4:0]        h_cons_q;

	logic              ov_q;
	key_t              o_code_q;
	logic [31:0]       o_bytes_q;
	logic [2:0]        o_len_q;
	logic [4:0]        o_cons_q;
	logic              o_last_q;

	logic [7:0]        cb;
	logic [2:0]        cb_need;
	logic [7:0]        seq_n;
	logic              u_full;
	logic              u_good;

	assign cb      = rq_q[0];
	assign cb_need = utf8_len(cb);
	assign seq_n   = 8'(plen_q) + 8'd2;
	assign u_full  = (({1'b0, ucnt_q} + 3'd1) == uneed_q);
	assign u_good  = (cb[7:6] == 2'b10)
		&& (ucnt_q < 2'd2 || ub_q[1][7:6] == 2'b10)
		&& (ucnt_q < 2'd3 || ub_q[2][7:6] == 2'b10);

	always_comb begin
		e_emit   = 1'b0;
		e_code   = KEY_NONE;
		e_bytes  = '0;
		e_len    = '0;
		e_cons   = '0;
		m_nx     = mode_q;
		plen_nx  = plen_q;
		prm_nx   = prm_q;
		ub_nx    = ub_q;
		ucnt_nx  = ucnt_q;
		uneed_nx = uneed_q;
		rq_nx    = rq_q;
		rcnt_nx  = rcnt_q;
		flush_nx = flush_q;
		if (rcnt_q != 2'd0) begin
			rq_nx[0] = rq_q[1];
			rq_nx[1] = rq_q[2];
			rcnt_nx  = rcnt_q - 2'd1;
			case (mode_q)
				PM_IDLE: begin
					if (cb == B_ESC) begin
						m_nx = PM_ESC;
					end else if (cb < B_SPACE || cb == B_DEL) begin
						e_emit = 1'b1;
						e_code = ctl_key(cb);
						e_cons = 5'd1;
					end else if (cb_need == 3'd1) begin
						e_emit  = 1'b1;
						e_code  = KEY_CHAR;
						e_bytes = {24'd0, cb};
						e_len   = 3'd1;
						e_cons  = 5'd1;
					end else if (cb_need == 3'd0) begin
						e_emit = 1'b1;
						e_cons = 5'd1;
					end else begin
						m_nx     = PM_UTF;
						ub_nx[0] = cb;
						ucnt_nx  = 2'd1;
						uneed_nx = cb_need;
					end
				end
				PM_ESC: begin
					if (cb == B_CSI || cb == B_SS3) begin
						m_nx    = PM_SEQ;
						plen_nx = '0;
					end else begin
						e_emit = 1'b1;
						e_cons = 5'd2;
						m_nx   = PM_IDLE;
					end
				end
				PM_SEQ: begin
					if (cb >= B_FIN_LO && cb <= B_FIN_HI) begin
						e_emit = 1'b1;
						e_code = seq_key(plen_q, prm_q[0], prm_q[1], prm_q[2], cb);
						e_cons = 5'(seq_n + 8'd1);
						m_nx   = PM_IDLE;
					end else if (cb < B_SPACE || cb > B_FIN_HI) begin
						// broken sequence: drop what came before, decode this byte again
						e_emit  = 1'b1;
						e_cons  = 5'(seq_n);
						m_nx    = PM_IDLE;
						rq_nx   = rq_q;
						rcnt_nx = rcnt_q;
					end else if ((seq_n + 8'd1) == 8'(ESC_MAX)) begin
						e_emit = 1'b1;
						e_cons = 5'(ESC_MAX);
						m_nx   = PM_IDLE;
					end else begin
						if (plen_q < PLEN_W'(3))
							prm_nx[plen_q[1:0]] = cb;
						plen_nx = plen_q + PLEN_W'(1);
					end
				end
				PM_UTF: begin
					if (!u_full) begin
						ub_nx[ucnt_q] = cb;
						ucnt_nx       = ucnt_q + 2'd1;
					end else if (u_good) begin
						e_emit      = 1'b1;
						e_code      = KEY_CHAR;
						e_bytes[7:0] = ub_q[0];
						if (ucnt_q >= 2'd2)
							e_bytes[15:8] = ub_q[1];
						if (ucnt_q == 2'd3)
							e_bytes[23:16] = ub_q[2];
						e_bytes[{ucnt_q, 3'b000} +: 8] = cb;
						e_len  = uneed_q;
						e_cons = {2'b00, uneed_q};
						m_nx   = PM_IDLE;
					end else begin
						// malformed: drop the lead, requeue the bytes after it ahead of the rest
						e_emit   = 1'b1;
						e_cons   = 5'd1;
						m_nx     = PM_IDLE;
						rq_nx[0] = (ucnt_q == 2'd1) ? cb : ub_q[1];
						if (ucnt_q == 2'd1)
							rq_nx[1] = rq_q[1];
						else if (ucnt_q == 2'd2)
							rq_nx[1] = cb;
						else
							rq_nx[1] = ub_q[2];
						if (ucnt_q == 2'd3)
							rq_nx[2] = cb;
						else if (ucnt_q == 2'd2)
							rq_nx[2] = rq_q[1];
						else
							rq_nx[2] = rq_q[2];
						rcnt_nx = 2'(3'(ucnt_q) + 3'(rcnt_q) - 3'd1);
					end
				end
				default: m_nx = PM_IDLE;
			endcase
		end else if (flush_q) begin
			flush_nx = 1'b0;
			m_nx     = PM_IDLE;
			case (mode_q)
				PM_ESC: begin
					e_emit = 1'b1;
					e_code = KEY_ESCAPE;
					e_cons = 5'd1;
				end
				PM_SEQ: begin
					e_emit = 1'b1;
					e_cons = 5'(seq_n);
				end
				PM_UTF: begin
					e_emit = 1'b1;
					e_cons = {3'b000, ucnt_q};
				end
				default: e_emit = 1'b0;
			endcase
		end
	end

	assign stat.work       = (rcnt_q != 2'd0) || flush_q;
	assign stat.emit       = e_emit;
	assign stat.held_valid = hv_q;
	assign stat.out_free   = !ov_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PM_IDLE;
			plen_q  <= '0;
			ucnt_q  <= '0;
			uneed_q <= '0;
			rcnt_q  <= '0;
			flush_q <= 1'b0;
			hv_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (req_type)
					flush_q <= 1'b1;
				else
					rcnt_q <= 2'd1;
			end
			if (cmd.step) begin
				mode_q  <= m_nx;
				plen_q  <= plen_nx;
				ucnt_q  <= ucnt_nx;
				uneed_q <= uneed_nx;
				rcnt_q  <= rcnt_nx;
				flush_q <= flush_nx;
				if (e_emit)
					hv_q <= 1'b1;
			end
			if (cmd.push_last)
				hv_q <= 1'b0;
			if (cmd.push || cmd.push_last)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !req_type)
			rq_q[0] <= data_byte;
		if (cmd.step) begin
			prm_q <= prm_nx;
			ub_q  <= ub_nx;
			rq_q  <= rq_nx;
			if (e_emit) begin
				h_code_q  <= e_code;
				h_bytes_q <= e_bytes;
				h_len_q   <= e_len;
				h_cons_q  <= e_cons;
			end
		end
		if (cmd.push || cmd.push_last) begin
			o_code_q  <= h_code_q;
			o_bytes_q <= h_bytes_q;
			o_len_q   <= h_len_q;
			o_cons_q  <= h_cons_q;
			o_last_q  <= cmd.push_last;
		end
	end

	assign out_valid  = ov_q;
	assign key_code   = o_code_q;
	assign char_bytes = o_bytes_q;
	assign char_len   = o_len_q;
	assign consumed   = o_cons_q;
	assign last       = o_last_q;

endmodule

// ----- hdl/terminal_key_decoder.sv -----
`timescale 1ns / 1ps
// a key moves from the byte queue through a decode step into the hold register and is
// pushed to the output register once it is free; a word is accepted only while idle,
// after the prior one is done; requeued utf-8 bytes, escape-breaking bytes and output
// stalls lengthen a word; the decoder takes one queued byte per cycle unless a new key
// waits on a full output; a word's last key is held until done so it can carry last
// reset: arst_n clears the controller, the parser (nothing pending) and out_valid at once
module terminal_key_decoder import tkd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input words: a terminal byte or a flush
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	// decoded keys
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  key_code,
	output logic [31:0] char_bytes,
	output logic [2:0]  char_len,
	output logic [4:0]  consumed,
	output logic        last
);

	// commands from the controller, status back from the datapath
	tkd_cmd_t  cmd;
	tkd_stat_t stat;

	// sequencing: accept a word, step the decoder until its queue and any flush are done
	// (a new key pushes out the held one), then push any held key out with last set
	tkd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// parser state for pending escape sequences and utf-8 chars, the byte queue
	// for replay, the hold register and the output register
	tkd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.cmd        (cmd),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.key_code   (key_code),
		.char_bytes (char_bytes),
		.char_len   (char_len),
		.consumed   (consumed),
		.last       (last)
	);

endmodule

// ----- hdl/tkd_checker.sv -----
`timescale 1ns / 1ps
// checker: port-level properties of the key decoder and its bind
module tkd_checker import tkd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  key_code,
	input logic [31:0] char_bytes,
	input logic [2:0]  char_len,
	input logic [4:0]  consumed,
	input logic        last
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_code)
			&& $stable(consumed) && $stable(last))
		else $error("output word changed while stalled");

	// only a char key carries bytes
	a_len_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((key_code == KEY_CHAR) == (char_len != 3'd0)))
		else $error("char_len does not match key_code");

	a_bytes_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_code != KEY_CHAR |-> char_bytes == 32'd0)
		else $error("non-char key with char bytes");

	// a char uses exactly its own bytes
	a_char_cons: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_code == KEY_CHAR |-> consumed == {2'b00, char_len})
		else $error("char key consumed count differs from length");

endmodule

bind terminal_key_decoder tkd_checker u_tkd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.key_code   (key_code),
	.char_bytes (char_bytes),
	.char_len   (char_len),
	.consumed   (consumed),
	.last       (last)
);
